// ===== src/hcd_pkg.sv =====
// hcd_pkg: shared types and constants for the chunked transfer decoder
// no dependencies; imported by hcd_front, hcd_back and http_chunked_decoder
package hcd_pkg;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  localparam int unsigned CFG_W = 13;
  localparam logic [CFG_W-1:0] MAX_LINE_RESET = 13'd8191;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_NO_CRLF  = 2'd2;
  localparam logic [1:0] ERR_LINE_LEN = 2'd3;

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_SIZE_CR,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF,
    PH_FINISHED,
    PH_ERROR
  } phase_t;

  // one classified input byte
  typedef struct packed {
    logic [7:0] raw;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
  } class_t;

  // one result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       data_valid;
    logic       finished;
    logic [1:0] error_code;
  } res_t;

endpackage

// ===== src/hcd_fifo.sv =====
// hcd_fifo: small register queue with full/empty flags
// no package dependency; used between the decoder stages and at the output
module hcd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/hcd_front.sv =====
// hcd_front: classifies each raw body byte (hex digit value, CR, LF)
// depends on hcd_pkg; feeds the queue in front of hcd_back
module hcd_front (
  input  logic          [7:0] in_byte,
  output hcd_pkg::class_t     cls
);
  import hcd_pkg::*;

  logic       dec;
  logic       lower;
  logic       upper;
  logic [7:0] hv;

  always_comb begin
    dec   = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    lower = (in_byte >= 8'h61) && (in_byte <= 8'h66);
    upper = (in_byte >= 8'h41) && (in_byte <= 8'h46);
    if (dec) begin
      hv = in_byte - 8'h30;
    end else if (lower) begin
      hv = in_byte - 8'h57;
    end else if (upper) begin
      hv = in_byte - 8'h37;
    end else begin
      hv = 8'h00;
    end
    cls.raw     = in_byte;
    cls.is_hex  = dec || lower || upper;
    cls.hex_val = hv[3:0];
    cls.is_cr   = (in_byte == CHAR_CR);
    cls.is_lf   = (in_byte == CHAR_LF);
  end

endmodule

// ===== src/hcd_back.sv =====
// hcd_back: chunk framing state machine, size accumulator and line counter
// depends on hcd_pkg; consumes classified bytes, produces one result each
module hcd_back #(
  parameter int unsigned SIZE_BITS  = 32,
  parameter int unsigned LINE_LIMIT = 8192
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr,
  input  logic [hcd_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        take,
  input  hcd_pkg::class_t             cls,
  output hcd_pkg::res_t               res
);
  import hcd_pkg::*;

  localparam int unsigned LEN_W = $clog2(LINE_LIMIT) + 1;
  localparam int unsigned CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam logic [CMP_W-1:0] HARD_LIMIT = CMP_W'(LINE_LIMIT - 1);

  logic [CFG_W-1:0]     max_line;
  phase_t               phase;
  phase_t               phase_next;
  logic [SIZE_BITS-1:0] rc;
  logic [SIZE_BITS-1:0] rc_next;
  logic [LEN_W-1:0]     line_length;
  logic [LEN_W-1:0]     line_length_next;
  logic                 digits_done;
  logic                 digits_done_next;
  logic [1:0]           err;
  logic [1:0]           err_next;

  logic [CMP_W-1:0]     limit;
  logic [LEN_W-1:0]     len_inc;
  logic                 valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line <= MAX_LINE_RESET;
    end else if (cfg_wr) begin
      max_line <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SIZE;
      rc          <= '0;
      line_length <= '0;
      digits_done <= 1'b0;
      err         <= ERR_NONE;
    end else if (take) begin
      phase       <= phase_next;
      rc          <= rc_next;
      line_length <= line_length_next;
      digits_done <= digits_done_next;
      err         <= err_next;
    end
  end

  always_comb begin
    limit = (CMP_W'(max_line) > HARD_LIMIT) ? HARD_LIMIT : CMP_W'(max_line);
    len_inc = line_length + LEN_W'(1);
    phase_next       = phase;
    rc_next          = rc;
    line_length_next = line_length;
    digits_done_next = digits_done;
    err_next         = err;
    valid            = 1'b0;
    case (phase)
      PH_SIZE, PH_SIZE_CR: begin
        line_length_next = len_inc;
        if (CMP_W'(len_inc) > limit) begin
          err_next   = ERR_LINE_LEN;
          phase_next = PH_ERROR;
        end else if (phase == PH_SIZE_CR && cls.is_lf) begin
          line_length_next = '0;
          digits_done_next = 1'b0;
          phase_next       = (rc == '0) ? PH_FINISHED : PH_DATA;
        end else begin
          phase_next = cls.is_cr ? PH_SIZE_CR : PH_SIZE;
          if (!digits_done) begin
            if (!cls.is_hex) begin
              digits_done_next = 1'b1;
            end else if (|rc[SIZE_BITS-1 -: 4]) begin
              // next digit would not fit in the size register
              err_next   = ERR_OVERFLOW;
              phase_next = PH_ERROR;
            end else begin
              rc_next = {rc[SIZE_BITS-5:0], cls.hex_val};
            end
          end
        end
      end
      PH_DATA: begin
        valid   = 1'b1;
        rc_next = rc - SIZE_BITS'(1);
        if (rc == SIZE_BITS'(1)) begin
          phase_next = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (cls.is_cr) begin
          phase_next = PH_DATA_LF;
        end else begin
          err_next   = ERR_NO_CRLF;
          phase_next = PH_ERROR;
        end
      end
      PH_DATA_LF: begin
        if (cls.is_lf) begin
          phase_next       = PH_SIZE;
          line_length_next = '0;
          digits_done_next = 1'b0;
          rc_next          = '0;
        end else begin
          err_next   = ERR_NO_CRLF;
          phase_next = PH_ERROR;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
    res.out_byte   = valid ? cls.raw : 8'h00;
    res.data_valid = valid;
    res.finished   = (phase_next == PH_FINISHED);
    res.error_code = err_next;
  end

endmodule

// ===== src/http_chunked_decoder.sv =====
// http_chunked_decoder: top level of the chunked transfer body decoder
// depends on hcd_pkg, hcd_front, hcd_fifo, hcd_back
//
//   channel  | handshake         | payload
//   ---------+-------------------+---------------------------------------------
//   input    | push / full       | in_byte
//   result   | pop / empty       | out_byte, data_valid, finished, error_code
//   config   | cfg_wr            | cfg_data (max_line_bytes)
//
// one byte per cycle sustained while the result queue has room; the state update
// in hcd_back sets that figure. a byte is classified as it enters the front queue;
// once taken, its state update and its result queue write happen at the same edge.
// rst is synchronous and clears both queues, the framing state and errors;
// max_line_bytes returns to 8191. either side may stall on its own: the
// back stage holds while the result queue is full, the front while its queue is.
module http_chunked_decoder #(
  parameter int unsigned SIZE_BITS  = 32,
  parameter int unsigned LINE_LIMIT = 8192
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [7:0]                in_byte,
  output logic                      full,
  input  logic                      cfg_wr,
  input  logic [hcd_pkg::CFG_W-1:0] cfg_data,
  output logic                      empty,
  input  logic                      pop,
  output logic [7:0]                out_byte,
  output logic                      data_valid,
  output logic                      finished,
  output logic [1:0]                error_code
);
  import hcd_pkg::*;

  localparam int unsigned CLS_W = $bits(class_t);
  localparam int unsigned RES_W = $bits(res_t);

  class_t cls_in;
  class_t cls_q;
  res_t   res_new;
  res_t   res_q;
  logic   q_empty;
  logic   r_full;
  logic   take;

  hcd_front u_front (
    .in_byte (in_byte),
    .cls     (cls_in)
  );

  hcd_fifo #(
    .WIDTH (CLS_W),
    .DEPTH (2)
  ) u_cls_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (push),
    .wdata (cls_in),
    .full  (full),
    .rd    (take),
    .rdata (cls_q),
    .empty (q_empty)
  );

  // one transaction moves from the front queue to the result queue
  assign take = !q_empty && !r_full;

  hcd_back #(
    .SIZE_BITS  (SIZE_BITS),
    .LINE_LIMIT (LINE_LIMIT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .cfg_data (cfg_data),
    .take     (take),
    .cls      (cls_q),
    .res      (res_new)
  );

  hcd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (take),
    .wdata (res_new),
    .full  (r_full),
    .rd    (pop),
    .rdata (res_q),
    .empty (empty)
  );

  assign out_byte   = res_q.out_byte;
  assign data_valid = res_q.data_valid;
  assign finished   = res_q.finished;
  assign error_code = res_q.error_code;

endmodule
